// ===== design/cbh_pkg.sv =====
`timescale 1ns / 1ps

package cbh_pkg;

  localparam int SectionsDef   = 4;
  localparam int SampleBitsDef = 16;

  localparam int DataW = 32;
  localparam int CoefW = 32;
  localparam int ProdW = DataW + CoefW;
  // Five full products summed exactly need three guard bits.
  localparam int AccW  = ProdW + 3;
  localparam int RowW  = 3;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [CoefW-1:0] coef_t;

  typedef logic [2:0] tap_t;
  localparam tap_t TAP_B0 = 3'd0;
  localparam tap_t TAP_B1 = 3'd1;
  localparam tap_t TAP_B2 = 3'd2;
  localparam tap_t TAP_A1 = 3'd3;
  localparam tap_t TAP_A2 = 3'd4;

  typedef struct packed {
    logic issue;
    logic negate;
    logic clear;
  } mac_ctrl_t;

  localparam coef_t Q30One  = 32'sd1073741824;
  localparam coef_t Q30MTwo = 32'sh8000_0000;

  // Coefficients in Q2.30; rows past the fourth pass the sample through.
  function automatic coef_t coef_lookup(input logic [RowW-1:0] row, input tap_t tap);
    coef_t c;
    c = '0;
    unique case (row)
      3'd0: begin
        unique case (tap)
          TAP_B0:  c = 32'sd1049993350;
          TAP_B1:  c = -32'sd2099986701;
          TAP_B2:  c = 32'sd1049993350;
          TAP_A1:  c = -32'sd2129178542;
          TAP_A2:  c = 32'sd1055517794;
          default: c = '0;
        endcase
      end
      3'd1, 3'd2, 3'd3: begin
        unique case (tap)
          TAP_B0, TAP_B2: c = Q30One;
          TAP_B1:         c = Q30MTwo;
          TAP_A1: begin
            c = (row == 3'd1) ? -32'sd2131932895 :
                (row == 3'd2) ? -32'sd2137041069 : -32'sd2143752220;
          end
          TAP_A2: begin
            c = (row == 3'd1) ? 32'sd1058272252 :
                (row == 3'd2) ? 32'sd1063380620 : 32'sd1070092027;
          end
          default: c = '0;
        endcase
      end
      default: c = (tap == TAP_B0) ? Q30One : '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/cbh_if.sv =====
`timescale 1ns / 1ps

interface cbh_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cbh_out_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// ===== design/cbh_mac.sv =====
`timescale 1ns / 1ps

module cbh_mac import cbh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mac_ctrl_t ctrl_i,
  input  coef_t     coef_i,
  input  data_t     data_i,
  output data_t     y_o
);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_v_q;
  logic                    neg_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-1:0]  shifted;

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (CoefW - 3);
  localparam logic signed [AccW-1:0] DataMax   = AccW'({1'b0, {(DataW-1){1'b1}}});
  localparam logic signed [AccW-1:0] DataMin   = -DataMax - AccW'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= coef_i * data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      neg_q    <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.issue;
      neg_q    <= ctrl_i.negate;
      acc_q    <= acc_d;
    end
  end

  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  // The sum is Q6.61; round half up to Q1.31 and clamp to 32 bits.
  assign rnd     = acc_q + RoundHalf;
  assign shifted = rnd >>> (CoefW - 2);

  always_comb begin
    if (shifted > DataMax) begin
      y_o = DataMax[DataW-1:0];
    end else if (shifted < DataMin) begin
      y_o = DataMin[DataW-1:0];
    end else begin
      y_o = shifted[DataW-1:0];
    end
  end

endmodule

// ===== design/cbh_hist.sv =====
`timescale 1ns / 1ps

module cbh_hist import cbh_pkg::*; #(
  parameter int SECTIONS = SectionsDef,
  parameter int SEC_W    = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SEC_W-1:0] sec_i,
  input  logic             wr_i,
  input  data_t            x_i,
  input  data_t            y_i,
  output data_t            in1_o,
  output data_t            in2_o,
  output data_t            out1_o,
  output data_t            out2_o
);

  data_t in1_q  [SECTIONS];
  data_t in2_q  [SECTIONS];
  data_t out1_q [SECTIONS];
  data_t out2_q [SECTIONS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        in1_q[i]  <= '0;
        in2_q[i]  <= '0;
        out1_q[i] <= '0;
        out2_q[i] <= '0;
      end
    end else if (wr_i) begin
      in2_q[sec_i]  <= in1_q[sec_i];
      in1_q[sec_i]  <= x_i;
      out2_q[sec_i] <= out1_q[sec_i];
      out1_q[sec_i] <= y_i;
    end
  end

  assign in1_o  = in1_q[sec_i];
  assign in2_o  = in2_q[sec_i];
  assign out1_o = out1_q[sec_i];
  assign out2_o = out2_q[sec_i];

endmodule

// ===== design/cascaded_biquad_highpass.sv =====
`timescale 1ns / 1ps

// High-pass filter built from SECTIONS direct-form-I biquads in series, for
// removing baseline wander from signed Q1.(SAMPLE_BITS-1) samples. All five
// products of every section pass through one 32x32 multiplier and one
// accumulator, so a section runs in steps: five multiplies, one to drain
// the multiplier register and one to round and update the history. The input
// is not ready while an item is at work; it becomes ready again once the
// result is loaded, even while that result still waits to be taken. All
// filter history resets to zero.
module cascaded_biquad_highpass import cbh_pkg::*; #(
  parameter int SECTIONS    = SectionsDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cbh_in_if.sink   in_i,
  cbh_out_if.source out_o
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SHIFT = DataW - SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [SEC_W-1:0] LastSec = SEC_W'(SECTIONS - 1);

  localparam logic signed [DataW:0] OutHalf = (DataW+1)'(1) <<< (SHIFT - 1);
  localparam logic signed [DataW:0] SMax =
    (DataW+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [DataW:0] SMin = -SMax - (DataW+1)'(1);

  logic [2:0]       state_q, state_d;
  logic [SEC_W-1:0] sec_q, sec_d;
  tap_t             tap_q, tap_d;
  data_t            x_q, x_d;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic             out_valid_q, out_valid_d;
  logic             out_load;

  mac_ctrl_t mac_ctrl;
  coef_t     coef;
  data_t     operand;
  data_t     y;
  data_t     in1, in2, out1, out2;
  logic      hist_wr;

  logic signed [DataW:0] out_sum;
  logic signed [DataW:0] out_shr;
  logic signed [SAMPLE_BITS-1:0] out_sat;

  cbh_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef),
    .data_i (operand),
    .y_o    (y)
  );

  cbh_hist #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sec_i  (sec_q),
    .wr_i   (hist_wr),
    .x_i    (x_q),
    .y_i    (y),
    .in1_o  (in1),
    .in2_o  (in2),
    .out1_o (out1),
    .out2_o (out2)
  );

  assign coef = coef_lookup(RowW'(sec_q), tap_q);

  always_comb begin
    unique case (tap_q)
      TAP_B0:  operand = x_q;
      TAP_B1:  operand = in1;
      TAP_B2:  operand = in2;
      TAP_A1:  operand = out1;
      TAP_A2:  operand = out2;
      default: operand = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    sec_d    = sec_q;
    tap_d    = tap_q;
    x_d      = x_q;
    mac_ctrl = '0;
    hist_wr  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          x_d     = data_t'({in_i.sample_in, {SHIFT{1'b0}}});
          sec_d   = '0;
          tap_d   = TAP_B0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctrl.issue  = 1'b1;
        mac_ctrl.negate = (tap_q == TAP_A1) || (tap_q == TAP_A2);
        if (tap_q == TAP_A2) begin
          state_d = ST_DRAIN;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        hist_wr        = 1'b1;
        mac_ctrl.clear = 1'b1;
        x_d            = y;
        tap_d          = TAP_B0;
        if (sec_q == LastSec) begin
          state_d = ST_OUT;
        end else begin
          sec_d   = sec_q + SEC_W'(1);
          state_d = ST_MAC;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Round half up from Q1.31 to the sample format and clamp.
  assign out_sum = {x_q[DataW-1], x_q} + OutHalf;
  assign out_shr = out_sum >>> SHIFT;

  always_comb begin
    if (out_shr > SMax) begin
      out_sat = SMax[SAMPLE_BITS-1:0];
    end else if (out_shr < SMin) begin
      out_sat = SMin[SAMPLE_BITS-1:0];
    end else begin
      out_sat = out_shr[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      tap_q       <= TAP_B0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (out_load) begin
      out_q <= out_sat;
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cbh_pkg::*;

  localparam int Sections = SectionsDef;
  localparam int SampleW  = SampleBitsDef;
  localparam int Taps     = 5;
  // Allows for every section plus load and output, with some slack.
  localparam int DrainCycles = 7 * Sections + 10;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [71:0] wide_t;

  class highpass_scoreboard;
    coef_t   coef[Sections][Taps];
    data_t   in_z1[Sections];
    data_t   in_z2[Sections];
    data_t   out_z1[Sections];
    data_t   out_z2[Sections];
    sample_t expected_samples[$];
    int      errors;

    function new();
      coef = '{
        '{32'sd1049993350, -32'sd2099986701, 32'sd1049993350,
          -32'sd2129178542, 32'sd1055517794},
        '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824,
          -32'sd2131932895, 32'sd1058272252},
        '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824,
          -32'sd2137041069, 32'sd1063380620},
        '{32'sd1073741824, 32'sh8000_0000, 32'sd1073741824,
          -32'sd2143752220, 32'sd1070092027}
      };
      foreach (in_z1[k]) begin
        in_z1[k]  = '0;
        in_z2[k]  = '0;
        out_z1[k] = '0;
        out_z2[k] = '0;
      end
      errors = 0;
    endfunction

    // Runs one sample through every section and updates the history.
    function sample_t filter_sample(sample_t s);
      wide_t              acc;
      data_t              x;
      data_t              y;
      logic signed [32:0] t;
      sample_t            res;
      x = {s, {(DataW - SampleW){1'b0}}};
      for (int k = 0; k < Sections; k++) begin
        acc = coef[k][TAP_B0] * x
            + coef[k][TAP_B1] * in_z1[k]
            + coef[k][TAP_B2] * in_z2[k]
            - coef[k][TAP_A1] * out_z1[k]
            - coef[k][TAP_A2] * out_z2[k];
        acc = acc + 72'sd536870912;
        acc = acc >>> 30;
        if (acc > 72'sd2147483647) begin
          y = 32'sh7fff_ffff;
        end else if (acc < -72'sd2147483648) begin
          y = 32'sh8000_0000;
        end else begin
          y = acc[31:0];
        end
        in_z2[k]  = in_z1[k];
        in_z1[k]  = x;
        out_z2[k] = out_z1[k];
        out_z1[k] = y;
        x = y;
      end
      t = x + 33'sd32768;
      t = t >>> (DataW - SampleW);
      if (t > 33'sd32767) begin
        res = 16'sh7fff;
      end else if (t < -33'sd32768) begin
        res = 16'sh8000;
      end else begin
        res = t[SampleW-1:0];
      end
      return res;
    endfunction

    function void note_input(sample_t s);
      expected_samples.push_back(filter_sample(s));
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: unexpected output item %0d at %0t", got, $time);
        end
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: sample_out expected %0d, got %0d at %0t", want, got, $time);
          end
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   tx_idle;
  int   rx_idle;

  highpass_scoreboard sb = new();

  cbh_in_if  #(.W(SampleW)) in_bus ();
  cbh_out_if #(.W(SampleW)) out_bus ();

  cascaded_biquad_highpass #(
    .SECTIONS    (Sections),
    .SAMPLE_BITS (SampleW)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        sb.note_input(in_bus.sample_in);
      end
      if (out_bus.valid && out_bus.ready) begin
        sb.check_result(out_bus.sample_out);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < tx_idle) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= s;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  initial begin
    int      mode;
    int      wander;
    int      noise;
    int      v;
    sample_t s;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    tx_idle = 10;
    rx_idle = 10;
    rst_ni  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Impulse and extremes from rest.
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    // A full-scale step holds the internal nodes near their limits.
    repeat (5) send_sample(16'sd32767);
    // Alternating full scale sits at the pass band edge and drives the
    // section outputs and the final output into saturation.
    for (int i = 0; i < 12; i++) begin
      send_sample(i[0] ? 16'sd32767 : -16'sd32768);
    end
    send_sample(16'sd0);
    send_sample(16'sd0);

    wander = 0;
    mode   = 0;
    for (int i = 0; i < 1350; i++) begin
      if (i == 400) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (i == 700) begin
        tx_idle = 10;
        rx_idle = 10;
      end
      if (i % 20 == 0) begin
        v = $urandom_range(99);
        mode = (v < 35) ? 0 : (v < 55) ? 1 : (v < 85) ? 2 : (v < 95) ? 3 : 4;
      end
      case (mode)
        0: s = sample_t'($urandom_range(65535));
        1: s = sample_t'(int'($urandom_range(511)) - 256);
        2: begin
          // Slow drift with a little noise, like baseline wander under a signal.
          wander = wander + int'($urandom_range(400)) - 200;
          if (wander > 30000) wander = 30000;
          if (wander < -30000) wander = -30000;
          noise = int'($urandom_range(2000)) - 1000;
          s = sample_t'(wander + noise);
        end
        3: s = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        default: s = i[0] ? 16'sd32767 : -16'sd32768;
      endcase
      send_sample(s);
    end
    in_bus.valid <= 1'b0;

    while (sb.expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
